// ===== rtl/stg_pkg.sv =====
`timescale 1ns / 1ps

package stg_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RELEASE_SAMPLES = 2'd0,
    CFG_AMPLITUDE       = 2'd1,
    CFG_LOWPASS_COEFF   = 2'd2,
    CFG_SAMPLE_RATE     = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [15:0] RELEASE_SAMPLES_RST = 16'd1800;
  localparam logic [14:0] AMPLITUDE_RST       = 15'd8000;
  localparam logic [15:0] LOWPASS_COEFF_RST   = 16'd29950;
  localparam logic [16:0] SAMPLE_RATE_RST     = 17'd44100;

  // Enables from the pipeline control to the filter datapath.
  typedef struct packed {
    logic load_term;
    logic update;
  } lpf_ctl_t;

endpackage

// ===== rtl/stg_osc.sv =====
`timescale 1ns / 1ps

module stg_osc
  import stg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               speaker_on,
  input  logic [15:0]        tone_freq,
  input  logic [15:0]        release_samples,
  input  logic [14:0]        amplitude,
  input  logic [16:0]        sample_rate,
  output logic signed [15:0] raw
);

  logic [15:0]        release_left_r, release_left_nxt;
  logic [16:0]        phase_r, phase_nxt;
  logic signed [15:0] raw_r, raw_nxt;
  logic [16:0]        modulus;
  logic [16:0]        step_val;
  logic [17:0]        sum;
  logic [17:0]        wrap1;
  logic               playing;

  // Release counter and square-wave phase for the current transfer.
  always_comb begin
    modulus          = (sample_rate == 17'd0) ? 17'd1 : sample_rate;
    release_left_nxt = release_left_r;
    playing          = 1'b0;
    if (speaker_on) begin
      release_left_nxt = release_samples;
      playing          = 1'b1;
    end else if (release_left_r != 16'd0) begin
      release_left_nxt = release_left_r - 16'd1;
      playing          = 1'b1;
    end

    // The phase step saturates just below the modulus.
    step_val = ({1'b0, tone_freq} > (modulus - 17'd1)) ? (modulus - 17'd1)
                                                        : {1'b0, tone_freq};
    sum   = {1'b0, phase_r} + {1'b0, step_val};
    wrap1 = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
    if (wrap1 >= {1'b0, modulus}) begin
      wrap1 = 18'd0;
    end

    phase_nxt = phase_r;
    raw_nxt   = 16'sd0;
    if (playing && (tone_freq != 16'd0)) begin
      phase_nxt = wrap1[16:0];
      if ({phase_r, 1'b0} < {1'b0, modulus}) begin
        raw_nxt = $signed({1'b0, amplitude});
      end else begin
        raw_nxt = -$signed({1'b0, amplitude});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_left_r <= 16'd0;
      phase_r        <= 17'd0;
    end else if (step) begin
      release_left_r <= release_left_nxt;
      phase_r        <= phase_nxt;
    end
  end

  // Raw square value, held for the filter stage.
  always_ff @(posedge clk) begin
    if (step) begin
      raw_r <= raw_nxt;
    end
  end

  assign raw = raw_r;

endmodule

// ===== rtl/stg_lpf.sv =====
`timescale 1ns / 1ps

module stg_lpf
  import stg_pkg::*;
#(
  parameter int FILTER_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lpf_ctl_t           ctl,
  input  logic signed [15:0] raw,
  input  logic [15:0]        lowpass_coeff,
  output logic signed [15:0] sample
);

  localparam int ACC_W = ((32 + FILTER_FRAC_BITS > 48) ? 32 + FILTER_FRAC_BITS : 48) + 1;
  localparam int Q_W   = 33;

  logic [16:0]             one_minus_c;
  logic signed [33:0]      term_prod;
  logic signed [31:0]      term_r, term_nxt;
  logic signed [48:0]      fb_prod;
  logic signed [ACC_W-1:0] term_ext;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_shr;
  logic signed [31:0]      filter_r, filter_nxt;
  logic signed [Q_W-1:0]   biased;
  logic signed [Q_W-1:0]   quot;
  logic signed [15:0]      sample_r, sample_nxt;

  // Input weight: (1 - c) * raw, registered ahead of the feedback loop.
  always_comb begin
    one_minus_c = 17'h10000 - {1'b0, lowpass_coeff};
    term_prod   = $signed({1'b0, one_minus_c}) * raw;
    term_nxt    = term_prod[31:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_term) begin
      term_r <= term_nxt;
    end
  end

  // Feedback multiply-add, floor shift by 16 and 32-bit saturation.
  always_comb begin
    fb_prod  = $signed({1'b0, lowpass_coeff}) * filter_r;
    term_ext = ACC_W'(term_r) <<< FILTER_FRAC_BITS;
    acc      = term_ext + ACC_W'(fb_prod);
    acc_shr  = acc >>> 16;
    if ((&acc_shr[ACC_W-1:31]) || !(|acc_shr[ACC_W-1:31])) begin
      filter_nxt = acc_shr[31:0];
    end else if (acc_shr[ACC_W-1]) begin
      filter_nxt = 32'sh8000_0000;
    end else begin
      filter_nxt = 32'sh7fff_ffff;
    end

    // Integer part, truncated toward zero, saturated to 16 bits.
    biased = Q_W'(filter_nxt);
    if (filter_nxt[31]) begin
      biased = biased + $signed(Q_W'((64'd1 << FILTER_FRAC_BITS) - 64'd1));
    end
    quot = biased >>> FILTER_FRAC_BITS;
    if ((&quot[Q_W-1:15]) || !(|quot[Q_W-1:15])) begin
      sample_nxt = quot[15:0];
    end else if (quot[Q_W-1]) begin
      sample_nxt = 16'sh8000;
    end else begin
      sample_nxt = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= 32'sd0;
    end else if (ctl.update) begin
      filter_r <= filter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

// ===== rtl/speaker_tone_generator.sv =====
`timescale 1ns / 1ps

// Square-wave tone generator with a one-pole low-pass output filter. Each input
// transfer is one audio sample tick and produces exactly one signed 16-bit
// sample. The block takes one tick per clock cycle; a sample is presented once
// its tick has passed the oscillator register, the input-weight multiply
// register, then the filter and output register. The rate is set by the filter
// feedback loop, a single 16x32 multiply-add. The whole pipeline stalls only
// while the output register holds a sample that is not taken.
// Configuration must be written through the cfg port only while no tick is in
// flight; the block itself does not enforce this.

module speaker_tone_generator
  import stg_pkg::*;
#(
  parameter int FILTER_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_speaker_on,
  input  logic [15:0]        in_tone_freq,

  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_reg_t           cfg_index,
  input  logic [16:0]        cfg_data
);

  logic [15:0] release_samples_r;
  logic [14:0] amplitude_r;
  logic [15:0] lowpass_coeff_r;
  logic [16:0] sample_rate_r;

  logic        osc_valid_r;
  logic        term_valid_r;
  logic        out_valid_r;
  logic        advance;
  logic        accept;
  lpf_ctl_t    lpf_ctl;

  logic signed [15:0] raw;

  // Configuration register writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_samples_r <= RELEASE_SAMPLES_RST;
      amplitude_r       <= AMPLITUDE_RST;
      lowpass_coeff_r   <= LOWPASS_COEFF_RST;
      sample_rate_r     <= SAMPLE_RATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RELEASE_SAMPLES: release_samples_r <= cfg_data[15:0];
        CFG_AMPLITUDE:       amplitude_r       <= cfg_data[14:0];
        CFG_LOWPASS_COEFF:   lowpass_coeff_r   <= cfg_data[15:0];
        CFG_SAMPLE_RATE:     sample_rate_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // All stages move together unless the output sample is held.
  assign advance           = !out_valid_r || out_ready;
  assign in_ready          = advance;
  assign accept            = in_valid && advance;
  assign lpf_ctl.load_term = advance && osc_valid_r;
  assign lpf_ctl.update    = advance && term_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_valid_r  <= 1'b0;
      term_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      osc_valid_r  <= in_valid;
      term_valid_r <= osc_valid_r;
      out_valid_r  <= term_valid_r;
    end
  end

  stg_osc u_osc (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (accept),
    .speaker_on      (in_speaker_on),
    .tone_freq       (in_tone_freq),
    .release_samples (release_samples_r),
    .amplitude       (amplitude_r),
    .sample_rate     (sample_rate_r),
    .raw             (raw)
  );

  stg_lpf #(
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_lpf (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (lpf_ctl),
    .raw           (raw),
    .lowpass_coeff (lowpass_coeff_r),
    .sample        (out_sample)
  );

  assign out_valid = out_valid_r;

endmodule

// ===== bench/speaker_tone_generator_tb.sv =====
`timescale 1ns / 1ps

module speaker_tone_generator_tb;
  import stg_pkg::*;

  typedef struct packed {
    logic        on;
    logic [15:0] freq;
  } tick_t;

  localparam int RANDOM_PHASES   = 13;
  localparam int TICKS_PER_PHASE = 125;
  localparam int LONG_HOLD_AT    = 460;
  localparam int LONG_HOLD_LEN   = 150;
  localparam int SETTLE_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_speaker_on = 1'b0;
  logic [15:0]        in_tone_freq = 16'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index = CFG_RELEASE_SAMPLES;
  logic [16:0]        cfg_data = 17'd0;

  // Stimulus waiting for the driver, and samples waiting for the DUT.
  tick_t              pending_ticks[$];
  logic signed [15:0] expected_samples[$];
  tick_t              next_tick;

  // Predictor copy of the registers.
  logic [15:0] release_len = RELEASE_SAMPLES_RST;
  logic [14:0] amp_level   = AMPLITUDE_RST;
  logic [15:0] lp_coeff    = LOWPASS_COEFF_RST;
  logic [16:0] rate_hz     = SAMPLE_RATE_RST;

  // Predictor copy of the tone state.
  logic [15:0] release_count = 16'd0;
  logic [16:0] phase_acc = 17'd0;
  int          lp_state = 0;

  int send_gap = 0;
  int stall_left = 0;
  int samples_checked = 0;
  int ticks_taken = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit long_hold_done = 1'b0;
  // Set by the driver while a tick is offered and not yet taken.
  bit tick_offered = 1'b0;

  speaker_tone_generator DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_speaker_on(in_speaker_on),
    .in_tone_freq (in_tone_freq),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the tone state by one tick and return the filtered sample.
  function automatic logic signed [15:0] next_sample(input logic on, input logic [15:0] freq);
    logic        playing;
    longint      raw;
    longint      acc;
    longint      level;
    int unsigned modulus;
    int unsigned stride;
    int unsigned total;
    modulus = (rate_hz != 17'd0) ? 32'(rate_hz) : 32'd1;
    raw = 0;
    if (on) begin
      release_count = release_len;
      playing = 1'b1;
    end else if (release_count != 16'd0) begin
      release_count = release_count - 16'd1;
      playing = 1'b1;
    end else begin
      playing = 1'b0;
    end
    if (playing && freq != 16'd0) begin
      stride = 32'(freq);
      if (stride > modulus - 1) stride = modulus - 1;
      raw = (2 * phase_acc < modulus) ? longint'(amp_level) : -longint'(amp_level);
      total = phase_acc + stride;
      if (total >= modulus) total = total - modulus;
      if (total >= modulus) total = 0;
      phase_acc = total[16:0];
    end
    // One-pole low-pass in 16.16, floor of the weighted sum.
    acc = (65536 - longint'(lp_coeff)) * (raw <<< 16) + longint'(lp_coeff) * longint'(lp_state);
    acc = acc >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    lp_state = int'(acc);
    // Drop the fraction, rounding toward zero.
    if (lp_state >= 0) begin
      level = longint'(lp_state) >>> 16;
    end else begin
      level = -((-longint'(lp_state)) >>> 16);
    end
    if (level > 32767) level = 32767;
    if (level < -32768) level = -32768;
    return level[15:0];
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [15:0] pick_freq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 18) return 16'hFFFF;
    if (r < 28) return 16'($urandom_range(32768, 65535));
    if (r < 65) return 16'($urandom_range(20, 2000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Random register value, extremes and stray upper data bits included.
  function automatic logic [16:0] pick_setting(input cfg_reg_t idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (idx)
      CFG_RELEASE_SAMPLES: begin
        if (r < 10) return 17'd0;
        if (r < 20) return 17'd65535;
        if (r < 80) return 17'($urandom_range(1, 300));
        return 17'($urandom_range(0, 131071));
      end
      CFG_AMPLITUDE: begin
        if (r < 10) return 17'd0;
        if (r < 25) return 17'd32767;
        if (r < 40) return 17'($urandom_range(0, 131071));
        return 17'($urandom_range(0, 32767));
      end
      CFG_LOWPASS_COEFF: begin
        if (r < 10) return 17'd0;
        if (r < 20) return 17'd65535;
        if (r < 30) return 17'($urandom_range(0, 131071));
        if (r < 50) return 17'($urandom_range(25000, 35000));
        return 17'($urandom_range(0, 65535));
      end
      default: begin
        if (r < 4) return 17'd0;
        if (r < 8) return 17'd1;
        if (r < 12) return 17'd2;
        if (r < 20) return 17'd8000;
        if (r < 28) return 17'd96000;
        if (r < 34) return 17'd131071;
        if (r < 44) return 17'($urandom_range(0, 131071));
        if (r < 55) return 17'd44100;
        return 17'($urandom_range(8000, 96000));
      end
    endcase
  endfunction

  task automatic add_tick(input logic on, input logic [15:0] freq);
    tick_t t;
    t.on = on;
    t.freq = freq;
    pending_ticks.push_back(t);
  endtask

  // Write one register; cfg_valid stays high so writes can follow back to back.
  task automatic write_reg(input cfg_reg_t idx, input logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RELEASE_SAMPLES: release_len = data[15:0];
      CFG_AMPLITUDE:       amp_level = data[14:0];
      CFG_LOWPASS_COEFF:   lp_coeff = data[15:0];
      default:             rate_hz = data;
    endcase
    cfg_writes++;
  endtask

  // Hold off until every tick is sent and every sample is back, then let the
  // pipeline settle.
  task automatic drain_all();
    while (pending_ticks.size() != 0 || tick_offered || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: one tick per transfer, random gaps between ticks.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_samples.push_back(next_sample(in_speaker_on, in_tone_freq));
        ticks_taken++;
        tick_offered = 1'b0;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          next_tick = pending_ticks.pop_front();
          tick_offered = 1'b1;
          in_valid <= 1'b1;
          in_speaker_on <= next_tick.on;
          in_tone_freq <= next_tick.freq;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void next_expected_check(input logic signed [15:0] want);
    if (out_sample !== want) begin
      $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, out_sample);
      mismatches++;
    end
  endfunction

  // Output monitor: compares each sample transfer and applies back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, got %0d", $time, out_sample);
          mismatches++;
        end else begin
          next_expected_check(expected_samples.pop_front());
        end
        samples_checked++;
        // One long hold while the driver keeps offering ticks.
        if (samples_checked == LONG_HOLD_AT && !long_hold_done) begin
          stall_left = LONG_HOLD_LEN;
          long_hold_done = 1'b1;
        end else if ($urandom_range(0, 99) < 25) begin
          stall_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready) &&
        !(cfg_valid && cfg_ready)) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d samples outstanding", $time,
               idle_cycles, expected_samples.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int          made;
    int          note_len;
    int          tail_len;
    logic [15:0] note_freq;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: silent tone, a normal tone, a saturated frequency, release.
    add_tick(1'b1, 16'd0);
    repeat (3) add_tick(1'b1, 16'd440);
    repeat (2) add_tick(1'b1, 16'hFFFF);
    repeat (2) add_tick(1'b0, 16'd440);
    add_tick(1'b0, 16'd0);
    drain_all();

    // Zero sample rate gives a constant level; no release time; filter bypassed.
    write_reg(CFG_RELEASE_SAMPLES, 17'd0);
    write_reg(CFG_AMPLITUDE, 17'd32767);
    write_reg(CFG_LOWPASS_COEFF, 17'd0);
    write_reg(CFG_SAMPLE_RATE, 17'd0);
    cfg_valid <= 1'b0;
    repeat (2) add_tick(1'b1, 16'd1);
    repeat (2) add_tick(1'b0, 16'd1);
    drain_all();

    // Upper extremes for most registers, with stray bits above the register widths.
    write_reg(CFG_RELEASE_SAMPLES, 17'h1FFFF);
    write_reg(CFG_AMPLITUDE, 17'h18000);
    write_reg(CFG_LOWPASS_COEFF, 17'h1FFFF);
    write_reg(CFG_SAMPLE_RATE, 17'h1FFFF);
    cfg_valid <= 1'b0;
    repeat (2) add_tick(1'b1, 16'hFFFF);
    add_tick(1'b0, 16'd0);
    drain_all();

    // Run the phase up high, then lower the rate below it.
    write_reg(CFG_RELEASE_SAMPLES, 17'd2);
    write_reg(CFG_AMPLITUDE, 17'd20000);
    write_reg(CFG_LOWPASS_COEFF, 17'd1);
    write_reg(CFG_SAMPLE_RATE, 17'd96000);
    cfg_valid <= 1'b0;
    repeat (2) add_tick(1'b1, 16'd47000);
    drain_all();
    write_reg(CFG_SAMPLE_RATE, 17'd8000);
    cfg_valid <= 1'b0;
    add_tick(1'b1, 16'd7000);
    repeat (2) add_tick(1'b1, 16'd9000);
    repeat (3) add_tick(1'b0, 16'd9000);
    drain_all();

    // Random phases: notes with release tails, a little noise mixed in.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 9) < 7) write_reg(CFG_RELEASE_SAMPLES, pick_setting(CFG_RELEASE_SAMPLES));
      if ($urandom_range(0, 9) < 7) write_reg(CFG_AMPLITUDE, pick_setting(CFG_AMPLITUDE));
      if ($urandom_range(0, 9) < 7) write_reg(CFG_LOWPASS_COEFF, pick_setting(CFG_LOWPASS_COEFF));
      if ($urandom_range(0, 9) < 7) write_reg(CFG_SAMPLE_RATE, pick_setting(CFG_SAMPLE_RATE));
      cfg_valid <= 1'b0;
      made = 0;
      while (made < TICKS_PER_PHASE) begin
        note_freq = pick_freq();
        note_len = $urandom_range(1, 12);
        tail_len = $urandom_range(0, 25);
        for (int k = 0; k < note_len + tail_len && made < TICKS_PER_PHASE; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            add_tick(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
          end else if (k < note_len) begin
            add_tick(1'b1, note_freq);
          end else begin
            add_tick(1'b0, ($urandom_range(0, 4) == 0) ? pick_freq() : note_freq);
          end
          made++;
        end
      end
      drain_all();
    end

    $display("Sent %0d ticks over %0d register writes, including zero and maximum rates.",
             ticks_taken, cfg_writes);
    $display("Compared %0d samples, %0d mismatches.", samples_checked, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stg_pkg.sv
rtl/stg_osc.sv
rtl/stg_lpf.sv
rtl/speaker_tone_generator.sv
bench/speaker_tone_generator_tb.sv
